/* rtl/ita_pkg.sv */
// ita_pkg: shared types, constants and helpers for the integer-to-ascii converter
`default_nettype none

package ita_pkg;

  // radix and digit field width, ascii character width
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned CHAR_W  = 7;

  // clamping limits for the base, and the decimal base
  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [RADIX_W-1:0] DIGIT_MAX_DEC = 6'd9;
  localparam logic [CHAR_W-1:0]  LETTER_OFS    = 7'd10;

  // conversion sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVGO,
    S_DIVWAIT,
    S_SIGN,
    S_RD,
    S_OUT
  } ita_state_e;

  // status returned by the shared divider
  typedef struct packed {
    logic               done;
    logic [RADIX_W-1:0] rem;
  } div_stat_t;

  // digit value to ascii character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d > DIGIT_MAX_DEC) begin
      digit_char = dx - LETTER_OFS + CHAR_A;
    end else begin
      digit_char = dx + CHAR_ZERO;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/ita_div.sv */
// ita_div: iterative divider by a small base, eight quotient bits per cycle
`default_nettype none

module ita_div
  import ita_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [VALUE_BITS-1:0] dividend_i,
  input  wire logic [RADIX_W-1:0]    divisor_i,
  output      logic [VALUE_BITS-1:0] quotient_o,
  output      div_stat_t             stat_o
);

  localparam int unsigned STEP_BITS = 8;
  localparam int unsigned STEPS     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned PAD_BITS  = STEPS * STEP_BITS;
  localparam int unsigned CNT_W     = $clog2(STEPS + 1);

  logic [PAD_BITS-1:0] dvd_q, dvd_d;
  logic [RADIX_W-1:0]  rem_q, rem_d;
  logic [RADIX_W-1:0]  div_q, div_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                done_q, done_d;

  // one cycle of restoring division: STEP_BITS dependent narrow compare-subtracts
  logic [PAD_BITS-1:0] sh;
  logic [RADIX_W-1:0]  r;
  logic [RADIX_W:0]    t;
  always_comb begin
    sh = dvd_q;
    r  = rem_q;
    t  = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      t  = {r, sh[PAD_BITS-1]};
      sh = {sh[PAD_BITS-2:0], 1'b0};
      if (t >= {1'b0, div_q}) begin
        r     = RADIX_W'(t - {1'b0, div_q});
        sh[0] = 1'b1;
      end else begin
        r = t[RADIX_W-1:0];
      end
    end
  end

  // load on start, then iterate while the step count runs down
  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = PAD_BITS'(dividend_i);
      rem_d = '0;
      div_d = divisor_i;
      cnt_d = CNT_W'(STEPS);
    end else if (cnt_q != '0) begin
      dvd_d  = sh;
      rem_d  = r;
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign quotient_o = dvd_q[VALUE_BITS-1:0];
  assign stat_o     = '{done: done_q, rem: rem_q};

endmodule

`default_nettype wire

/* rtl/int_to_ascii_radix_core.sv */
// int_to_ascii_radix_core: converts an integer to ascii digits in base 2..36 (signed in base 10)
//
//  channel  | dir | fields (lowest bit first)          | transfer
//  s_axis   | in  | tdata: value, radix                 | tvalid & tready
//  m_axis   | out | tdata: char_out, tlast: last_char   | tvalid & tready
//
// each digit costs one pass of the shared divider, and each character is then
// read back from the digit store
// the input is taken only when the sequencer is idle; a pending last character
// may still wait in the output register while the next number is accepted
// a stalled output holds the sequencer; reset clears control state only
`default_nettype none

module int_to_ascii_radix_core
  import ita_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // value, radix
  input  wire logic [((VALUE_BITS+RADIX_W+7)/8)*8-1:0] s_axis_tdata_i,
  input  wire logic                                    s_axis_tvalid_i,
  output      logic                                    s_axis_tready_o,
  // char_out
  output      logic [7:0]                              m_axis_tdata_o,
  output      logic                                    m_axis_tlast_o,
  output      logic                                    m_axis_tvalid_o,
  input  wire logic                                    m_axis_tready_i
);

  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);
  localparam int unsigned IDX_W = $clog2(VALUE_BITS);

  ita_state_e state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  neg_q, neg_d;
  logic [RADIX_W-1:0]    base_q, base_d;
  logic [RADIX_W-1:0]    rd_data_q;
  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;

  logic [RADIX_W-1:0]    digit_mem [VALUE_BITS];

  logic                  accept;
  logic                  out_free;
  logic [VALUE_BITS-1:0] in_value;
  logic [RADIX_W-1:0]    in_radix;
  logic [RADIX_W-1:0]    base_clamp;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;
  logic                  div_start;
  logic [VALUE_BITS-1:0] quotient;
  div_stat_t             div_stat;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [RADIX_W-1:0]    mem_wdata;
  logic [CNT_W-1:0]      cnt_dec;
  logic [IDX_W-1:0]      rd_addr;
  logic                  div_last;

  // input unpack, base clamp and sign handling
  assign in_value = s_axis_tdata_i[VALUE_BITS-1:0];
  assign in_radix = s_axis_tdata_i[VALUE_BITS +: RADIX_W];
  always_comb begin
    if (in_radix < RADIX_MIN) begin
      base_clamp = RADIX_MIN;
    end else if (in_radix > RADIX_MAX) begin
      base_clamp = RADIX_MAX;
    end else begin
      base_clamp = in_radix;
    end
  end
  assign in_neg = in_value[VALUE_BITS-1] && (base_clamp == RADIX_DEC);
  assign in_mag = in_neg ? (~in_value + VALUE_BITS'(1)) : in_value;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign cnt_dec         = cnt_q - CNT_W'(1);
  assign rd_addr         = cnt_dec[IDX_W-1:0];
  assign div_last        = (quotient == '0) || (cnt_q + CNT_W'(1) == CNT_W'(VALUE_BITS));

  // shared divider
  ita_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(val_q),
    .divisor_i (base_q),
    .quotient_o(quotient),
    .stat_o    (div_stat)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (in_mag == '0) ? S_SIGN : S_DIVGO;
        end
      end
      S_DIVGO:   state_d = S_DIVWAIT;
      S_DIVWAIT: begin
        if (div_stat.done) begin
          state_d = div_last ? S_SIGN : S_DIVGO;
        end
      end
      S_SIGN: begin
        if (!neg_q || out_free) begin
          state_d = S_RD;
        end
      end
      S_RD:   state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = (cnt_q == CNT_W'(1)) ? S_IDLE : S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs and datapath updates
  always_comb begin
    cnt_d       = cnt_q;
    val_d       = val_q;
    neg_d       = neg_q;
    base_d      = base_q;
    div_start   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[IDX_W-1:0];
    mem_wdata   = div_stat.rem;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d  = in_mag;
          neg_d  = in_neg;
          base_d = base_clamp;
          cnt_d  = '0;
          if (in_mag == '0) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '0;
            cnt_d     = CNT_W'(1);
          end
        end
      end
      S_DIVGO: div_start = 1'b1;
      S_DIVWAIT: begin
        if (div_stat.done) begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
          val_d  = quotient;
        end
      end
      S_SIGN: begin
        if (neg_q && out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_MINUS;
          out_last_d  = 1'b0;
        end
      end
      S_RD: ;
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_char(rd_data_q);
          out_last_d  = (cnt_q == CNT_W'(1));
          cnt_d       = cnt_dec;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      val_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      neg_q       <= neg_d;
      val_q       <= val_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  // digit store: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= digit_mem[rd_addr];
  end

  assign m_axis_tdata_o  = {1'b0, out_char_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tvalid_o = out_valid_q;

  // idle means every digit of the previous number has been handed out
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> cnt_q == '0)
    else $error("digit count not drained at idle");

  // divider only reports completion while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == S_DIVWAIT)
    else $error("divider done outside wait state");

  // a character load from the store always has a digit left
  a_out_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT || state_q == S_RD) |-> cnt_q != '0)
    else $error("readout with empty digit count");

  // the last character is followed by a return to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free && cnt_q == CNT_W'(1)) |=> state_q == S_IDLE && out_last_q)
    else $error("final character did not end the number");

endmodule

`default_nettype wire
